// ===== design/brr_pkg.sv =====
// Shared types and constants for the BRR ADPCM sample decoder.
// Standalone package; imported by every module of the decoder.
`timescale 1ns / 1ps
`default_nettype none

package brr_pkg;

    localparam int SampleW = 16;
    localparam int NibW    = 4;
    localparam int FracW   = 6;
    // 64*t plus the largest prediction stays below 2**24
    localparam int SumW    = 25;

    localparam logic [FracW-1:0] RndBias = {FracW{1'b1}};

    // Prediction coefficients in 64ths
    localparam logic signed [SumW-1:0] CoefP1 = SumW'(60);
    localparam logic signed [SumW-1:0] CoefP2 = SumW'(122);
    localparam logic signed [SumW-1:0] CoefQ2 = SumW'(60);
    localparam logic signed [SumW-1:0] CoefP3 = SumW'(115);
    localparam logic signed [SumW-1:0] CoefQ3 = SumW'(52);

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_ONE    = 2'd1,
        MODE_TWO    = 2'd2,
        MODE_THREE  = 2'd3
    } brr_mode_t;

    // One decoded data byte: two samples and the header flags in force
    typedef struct packed {
        logic signed [SampleW-1:0] first;
        logic signed [SampleW-1:0] second;
        logic                      end_flag;
        logic                      loop_flag;
    } brr_pair_t;

endpackage

`default_nettype wire

// ===== design/brr_filter.sv =====
// One sample evaluation: nibble expansion, range shift and 2-tap prediction.
// Depends on brr_pkg for widths, coefficients and the mode type.
`timescale 1ns / 1ps
`default_nettype none

module brr_filter import brr_pkg::*;
(
    input  wire logic        [NibW-1:0]    nibble,
    input  wire logic        [3:0]         shift,
    input  wire brr_mode_t                 mode,
    input  wire logic signed [SampleW-1:0] prev_in,
    input  wire logic signed [SampleW-1:0] older_in,
    output logic signed      [SampleW-1:0] sample
);

    logic        [SampleW-1:0] nib_ext;
    logic        [SampleW-1:0] shifted;
    logic signed [SumW-1:0]    base;
    logic signed [SumW-1:0]    p_ext;
    logic signed [SumW-1:0]    q_ext;
    logic signed [SumW-1:0]    pred;
    logic signed [SumW-1:0]    total;
    logic signed [SumW-1:0]    bias;
    logic signed [SumW-1:0]    rounded;

    assign nib_ext = {{(SampleW-NibW){nibble[NibW-1]}}, nibble};
    assign shifted = nib_ext << shift;
    assign base    = {{(SumW-SampleW-FracW){shifted[SampleW-1]}}, shifted, {FracW{1'b0}}};
    assign p_ext   = SumW'(prev_in);
    assign q_ext   = SumW'(older_in);

    always_comb
    begin
        unique case (mode)
            MODE_NONE:  pred = '0;
            MODE_ONE:   pred = p_ext * CoefP1;
            MODE_TWO:   pred = p_ext * CoefP2 - q_ext * CoefQ2;
            MODE_THREE: pred = p_ext * CoefP3 - q_ext * CoefQ3;
            default:    pred = '0;
        endcase
    end

    // truncate toward zero: bias negative sums before dropping the fraction
    assign total   = base + pred;
    assign bias    = total[SumW-1] ? SumW'(RndBias) : '0;
    assign rounded = total + bias;
    assign sample  = rounded[FracW+SampleW-1:FracW];

endmodule

`default_nettype wire

// ===== design/brr_out_buf.sv =====
// Result register holding one decoded pair; sends it out one sample at a time.
// Depends on brr_pkg for the pair type.
`timescale 1ns / 1ps
`default_nettype none

module brr_out_buf import brr_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      load,
    input  wire brr_pair_t                 pair_in,
    output logic                           free,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed      [SampleW-1:0] pcm_sample,
    output logic                           pair_last,
    output logic                           block_end,
    output logic                           block_loop
);

    brr_pair_t pair_reg;
    logic      valid_reg;
    logic      valid_next;
    logic      half_reg;
    logic      half_next;
    logic      done_first;
    logic      done_last;

    assign done_first = valid_reg && !half_reg && !out_stall;
    assign done_last  = valid_reg && half_reg && !out_stall;
    assign free       = !valid_reg || done_last;

    always_comb
    begin
        valid_next = valid_reg;
        half_next  = half_reg;
        priority if (load)
        begin
            valid_next = 1'b1;
            half_next  = 1'b0;
        end
        else if (done_last)
        begin
            valid_next = 1'b0;
            half_next  = 1'b0;
        end
        else if (done_first)
        begin
            half_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg;
            half_next  = half_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pair_reg <= pair_in;
        end
    end

    assign out_valid  = valid_reg;
    assign pcm_sample = half_reg ? pair_reg.second : pair_reg.first;
    assign pair_last  = half_reg;
    assign block_end  = pair_reg.end_flag;
    assign block_loop = pair_reg.loop_flag;

endmodule

`default_nettype wire

// ===== design/brr_adpcm_sample_decoder_unit.sv =====
// A data byte is decoded from the input register and enters the pair register
// once that is free; its high-nibble sample is offered from then on, the
// low-nibble sample in the cycle after it is taken. Headers need no result
// slot; the single output port sends one sample per cycle unless stalled.
// Reset clears the prediction history, the header fields and all valid flags.
// Depends on brr_pkg, brr_filter and brr_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module brr_adpcm_sample_decoder_unit import brr_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic        [7:0]         data_byte,
    input  wire logic                      is_header,
    input  wire logic                      sample_start,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed      [SampleW-1:0] pcm_sample,
    output logic                           pair_last,
    output logic                           block_end,
    output logic                           block_loop
);

    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic [7:0]                byte_reg;
    logic                      header_reg;
    logic                      start_reg;

    logic signed [SampleW-1:0] prev_reg;
    logic signed [SampleW-1:0] prev_next;
    logic signed [SampleW-1:0] older_reg;
    logic signed [SampleW-1:0] older_next;
    logic [3:0]                shift_reg;
    logic [3:0]                shift_next;
    brr_mode_t                 mode_reg;
    brr_mode_t                 mode_next;
    logic                      end_reg;
    logic                      end_next;
    logic                      loop_reg;
    logic                      loop_next;

    logic                      accept;
    logic                      advance;
    logic                      buf_free;
    logic                      buf_load;
    logic signed [SampleW-1:0] hist_p;
    logic signed [SampleW-1:0] hist_q;
    logic signed [SampleW-1:0] sample_hi;
    logic signed [SampleW-1:0] sample_lo;
    brr_pair_t                 pair;

    // a header needs no result slot; a data byte waits for the pair register
    assign advance  = in_valid_reg && (header_reg || buf_free);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign buf_load = advance && !header_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        priority if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg   <= data_byte;
            header_reg <= is_header;
            start_reg  <= sample_start;
        end
    end

    // drop the history at the start of a new sample
    assign hist_p = start_reg ? '0 : prev_reg;
    assign hist_q = start_reg ? '0 : older_reg;

    brr_filter u_filter_hi
    (
        .nibble   (byte_reg[7:4]),
        .shift    (shift_reg),
        .mode     (mode_reg),
        .prev_in  (hist_p),
        .older_in (hist_q),
        .sample   (sample_hi)
    );

    brr_filter u_filter_lo
    (
        .nibble   (byte_reg[3:0]),
        .shift    (shift_reg),
        .mode     (mode_reg),
        .prev_in  (sample_hi),
        .older_in (hist_p),
        .sample   (sample_lo)
    );

    always_comb
    begin
        prev_next  = prev_reg;
        older_next = older_reg;
        shift_next = shift_reg;
        mode_next  = mode_reg;
        end_next   = end_reg;
        loop_next  = loop_reg;
        if (advance)
        begin
            if (header_reg)
            begin
                prev_next  = hist_p;
                older_next = hist_q;
                shift_next = byte_reg[7:4];
                mode_next  = brr_mode_t'(byte_reg[3:2]);
                loop_next  = byte_reg[1];
                end_next   = byte_reg[0];
            end
            else
            begin
                prev_next  = sample_lo;
                older_next = sample_hi;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            older_reg <= '0;
            shift_reg <= '0;
            mode_reg  <= MODE_NONE;
            end_reg   <= 1'b0;
            loop_reg  <= 1'b0;
        end
        else
        begin
            prev_reg  <= prev_next;
            older_reg <= older_next;
            shift_reg <= shift_next;
            mode_reg  <= mode_next;
            end_reg   <= end_next;
            loop_reg  <= loop_next;
        end
    end

    assign pair.first     = sample_hi;
    assign pair.second    = sample_lo;
    assign pair.end_flag  = end_reg;
    assign pair.loop_flag = loop_reg;

    brr_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (buf_load),
        .pair_in    (pair),
        .free       (buf_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pcm_sample (pcm_sample),
        .pair_last  (pair_last),
        .block_end  (block_end),
        .block_loop (block_loop)
    );

`ifndef SYNTHESIS
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !pair_last) |=> (out_valid && pair_last))
        else $error("low-nibble sample did not follow the high-nibble sample");

    a_stall_only_data: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && !header_reg && !buf_free))
        else $error("input stalled without a data item waiting on the pair register");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && pair_last && !buf_load) |=> !out_valid)
        else $error("result offered after the pair was drained with no new load");
`endif

endmodule

`default_nettype wire
